// File: rtl/core/adbm_pkg.sv
// Shared types and fixed widths for the arcade drive brake mixer.
// Used by adbm_prod, adbm_scale and the top level; depends on nothing.

package adbm_pkg;

	localparam int unsigned CmdW      = 8;
	localparam int unsigned PowerW    = 9;
	localparam int unsigned BrakeW    = 8;
	localparam int unsigned FullScale = 128;
	localparam int unsigned PowNumW   = 14;
	localparam int unsigned BrkNumW   = 15;
	localparam int unsigned PowShift  = 21;
	localparam int unsigned BrkShift  = 22;
	localparam int unsigned PowRecipW = PowShift + 1;
	localparam int unsigned BrkRecipW = BrkShift + 1;

	typedef logic [CmdW-1:0]   cmd_t;
	typedef logic [PowerW-1:0] power_t;
	typedef logic [BrakeW-1:0] brake_t;

	typedef struct packed {
		cmd_t                 fwd;
		cmd_t                 trn;
		logic                 fwd_zero;
		logic                 inboard_right;
		logic                 brake;
		logic                 pow_neg;
		logic [PowNumW-1:0]   pow_num;
		logic [BrkNumW-1:0]   brk_num;
		brake_t               max_brk;
	} mix_prod_t;

endpackage

// File: rtl/core/adbm_prod.sv
// First stage of the mixer: magnitudes, inboard side and the two products
// that feed the constant divisions. Depends on adbm_pkg.

module adbm_prod #(
	parameter int unsigned TURN_DEADBAND = 50
) (
	input  adbm_pkg::cmd_t     fwd,
	input  adbm_pkg::cmd_t     trn,
	input  adbm_pkg::brake_t   max_braking,
	output adbm_pkg::mix_prod_t prod
);

	logic [7:0]  abs_fwd;
	logic [7:0]  abs_trn;
	logic [7:0]  dead;
	logic [7:0]  room;
	logic [7:0]  over;
	logic [8:0]  max_plus;
	logic [14:0] pow_full;
	logic [15:0] brk_full;

	assign dead     = 8'(TURN_DEADBAND);
	assign abs_fwd  = fwd[7] ? (8'd0 - fwd) : fwd;
	assign abs_trn  = trn[7] ? (8'd0 - trn) : trn;
	assign room     = dead - abs_trn;
	assign over     = abs_trn - dead;
	assign max_plus = {1'b0, max_braking} + 9'd1;
	assign pow_full = abs_fwd * room[6:0];
	assign brk_full = over[6:0] * max_plus;

	always_comb begin
		prod.fwd           = fwd;
		prod.trn           = trn;
		prod.fwd_zero      = (fwd == 8'd0);
		prod.inboard_right = trn[7] ? !fwd[7] : fwd[7];
		prod.brake         = (fwd != 8'd0) && (abs_trn >= dead);
		prod.pow_neg       = fwd[7];
		prod.pow_num       = pow_full[adbm_pkg::PowNumW-1:0];
		prod.brk_num       = brk_full[adbm_pkg::BrkNumW-1:0];
		prod.max_brk       = max_braking;
	end

endmodule

// File: rtl/core/adbm_scale.sv
// Second stage of the mixer: reciprocal multiplies for the two constant
// divisions and selection of the final powers and brake level. Depends on adbm_pkg.

module adbm_scale #(
	parameter int unsigned TURN_DEADBAND = 50
) (
	input  adbm_pkg::mix_prod_t prod,
	output adbm_pkg::power_t    left_pw,
	output adbm_pkg::power_t    right_pw,
	output logic                brk_valid,
	output logic                brk_side,
	output adbm_pkg::brake_t    brk_amount
);

	localparam int unsigned PowDen = TURN_DEADBAND;
	localparam int unsigned BrkDen = adbm_pkg::FullScale - TURN_DEADBAND;
	localparam logic [adbm_pkg::PowRecipW-1:0] PowRecip = adbm_pkg::PowRecipW'(
		((32'd1 << adbm_pkg::PowShift) + PowDen - 1) / PowDen);
	localparam logic [adbm_pkg::BrkRecipW-1:0] BrkRecip = adbm_pkg::BrkRecipW'(
		((32'd1 << adbm_pkg::BrkShift) + BrkDen - 1) / BrkDen);
	localparam int unsigned PowProdW = adbm_pkg::PowNumW + adbm_pkg::PowRecipW;
	localparam int unsigned BrkProdW = adbm_pkg::BrkNumW + adbm_pkg::BrkRecipW;

	logic [PowProdW-1:0] pow_prod;
	logic [BrkProdW-1:0] brk_prod;
	logic [8:0]          pow_quo;
	logic [8:0]          brk_quo;
	logic [8:0]          inboard;
	logic [8:0]          fwd9;
	logic [8:0]          trn9;
	logic [8:0]          left_base;
	logic [8:0]          right_base;

	assign pow_prod = PowProdW'(prod.pow_num) * PowProdW'(PowRecip);
	assign brk_prod = BrkProdW'(prod.brk_num) * BrkProdW'(BrkRecip);
	assign pow_quo  = pow_prod[adbm_pkg::PowShift +: 9];
	assign brk_quo  = brk_prod[adbm_pkg::BrkShift +: 9];
	assign inboard  = prod.pow_neg ? (9'd0 - pow_quo) : pow_quo;
	assign fwd9     = {prod.fwd[7], prod.fwd};
	assign trn9     = {prod.trn[7], prod.trn};

	always_comb begin
		if (prod.fwd_zero) begin
			left_base  = 9'd0 - trn9;
			right_base = trn9;
		end else begin
			left_base  = fwd9 - trn9;
			right_base = fwd9 + trn9;
		end
	end

	always_comb begin
		left_pw    = left_base;
		right_pw   = right_base;
		brk_valid  = 1'b0;
		brk_side   = 1'b0;
		brk_amount = '0;
		if (!prod.fwd_zero) begin
			if (prod.brake) begin
				if (prod.inboard_right) begin
					right_pw = '0;
				end else begin
					left_pw = '0;
				end
				brk_valid  = 1'b1;
				brk_side   = prod.inboard_right;
				brk_amount = (brk_quo > {1'b0, prod.max_brk}) ? prod.max_brk : brk_quo[7:0];
			end else begin
				if (prod.inboard_right) begin
					right_pw = inboard;
				end else begin
					left_pw = inboard;
				end
			end
		end
	end

endmodule

// File: rtl/core/arcade_drive_brake_mixer.sv
// Top level of the arcade drive brake mixer: handshakes, pipeline registers
// and the max_braking register. Depends on adbm_pkg, adbm_prod and adbm_scale.
//
// Usage:
// A command beat carries forward_cmd and turn_cmd on in_valid/in_ready. Each
// beat produces exactly one result beat on out_valid/out_ready with the left
// and right powers and the brake fields for the inboard side.
// The block is a three-register pipeline: an input register, a register after
// the two small products, and the result register after the reciprocal
// multiplies. One beat is accepted every cycle as long as the receiver takes
// results.
// When the receiver stalls, results stay in the result register and the
// earlier stages keep filling until all three hold a beat; in_ready then falls.
// Reset empties the pipeline and sets max_braking to 8. The register is
// written by cfg_wr_en/cfg_wr_data and should change only while no beat is
// in flight.

module arcade_drive_brake_mixer #(
	parameter int unsigned TURN_DEADBAND = 50
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic signed [7:0]       forward_cmd,
	input  logic signed [7:0]       turn_cmd,
	input  logic                    cfg_wr_en,
	input  logic [7:0]              cfg_wr_data,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [8:0]       left_power,
	output logic signed [8:0]       right_power,
	output logic                    brake_valid,
	output logic                    brake_side,
	output logic [7:0]              brake_amount
);

	localparam logic [7:0] MaxBrakingReset = 8'd8;

	adbm_pkg::brake_t    max_braking_q;
	logic                valid_s1;
	logic                valid_s2;
	logic                out_valid_q;
	adbm_pkg::cmd_t      fwd_s1;
	adbm_pkg::cmd_t      trn_s1;
	adbm_pkg::mix_prod_t prod_c;
	adbm_pkg::mix_prod_t prod_s2;
	adbm_pkg::power_t    left_c;
	adbm_pkg::power_t    right_c;
	logic                brk_valid_c;
	logic                brk_side_c;
	adbm_pkg::brake_t    brk_amount_c;
	adbm_pkg::power_t    left_q;
	adbm_pkg::power_t    right_q;
	logic                brk_valid_q;
	logic                brk_side_q;
	adbm_pkg::brake_t    brk_amount_q;
	logic                out_adv;
	logic                s2_adv;
	logic                s1_adv;

	assign out_adv  = !out_valid_q || out_ready;
	assign s2_adv   = !valid_s2 || out_adv;
	assign s1_adv   = !valid_s1 || s2_adv;
	assign in_ready = s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_braking_q <= MaxBrakingReset;
			valid_s1      <= 1'b0;
			valid_s2      <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				max_braking_q <= cfg_wr_data;
			end
			if (s1_adv) begin
				valid_s1 <= in_valid;
			end
			if (s2_adv) begin
				valid_s2 <= valid_s1;
			end
			if (out_adv) begin
				out_valid_q <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && in_valid) begin
			fwd_s1 <= forward_cmd;
			trn_s1 <= turn_cmd;
		end
		if (s2_adv && valid_s1) begin
			prod_s2 <= prod_c;
		end
		if (out_adv && valid_s2) begin
			left_q       <= left_c;
			right_q      <= right_c;
			brk_valid_q  <= brk_valid_c;
			brk_side_q   <= brk_side_c;
			brk_amount_q <= brk_amount_c;
		end
	end

	adbm_prod #(
		.TURN_DEADBAND(TURN_DEADBAND)
	) u_prod (
		.fwd        (fwd_s1),
		.trn        (trn_s1),
		.max_braking(max_braking_q),
		.prod       (prod_c)
	);

	adbm_scale #(
		.TURN_DEADBAND(TURN_DEADBAND)
	) u_scale (
		.prod      (prod_s2),
		.left_pw   (left_c),
		.right_pw  (right_c),
		.brk_valid (brk_valid_c),
		.brk_side  (brk_side_c),
		.brk_amount(brk_amount_c)
	);

	assign out_valid    = out_valid_q;
	assign left_power   = left_q;
	assign right_power  = right_q;
	assign brake_valid  = brk_valid_q;
	assign brake_side   = brk_side_q;
	assign brake_amount = brk_amount_q;

	// A braked side always carries zero power.
	a_brake_zero_power: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && brake_valid |->
			(brake_side ? (right_power == 9'sd0) : (left_power == 9'sd0)))
		else $error("braked side has nonzero power");

	// The brake level never exceeds the configured maximum.
	a_brake_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && brake_valid |-> (brake_amount <= max_braking_q))
		else $error("brake level above max_braking");

	// Without braking the brake fields are all zero.
	a_no_brake_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !brake_valid |-> (!brake_side && (brake_amount == 8'd0)))
		else $error("brake fields set without braking");

	// An accepted beat always occupies the input register on the next cycle.
	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> valid_s1)
		else $error("accepted beat lost at the input register");

endmodule

// File: bench/adbm_mix_checker.sv
// Checker for the arcade drive brake mixer: watches the command, result and
// configuration ports, predicts every result and compares it.
// Depends on adbm_pkg for the field types.
`timescale 1ns / 1ps

module adbm_mix_checker #(
	parameter int TurnDeadband = 50
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_ready,
	input  adbm_pkg::cmd_t   forward_cmd,
	input  adbm_pkg::cmd_t   turn_cmd,
	input  logic             cfg_wr_en,
	input  adbm_pkg::brake_t cfg_wr_data,
	input  logic             out_valid,
	input  logic             out_ready,
	input  adbm_pkg::power_t left_power,
	input  adbm_pkg::power_t right_power,
	input  logic             brake_valid,
	input  logic             brake_side,
	input  adbm_pkg::brake_t brake_amount,
	output int               mismatch_count,
	output int               pending_count
);

	localparam int FullScaleCounts = int'(adbm_pkg::FullScale);
	localparam int MaxReported     = 10;

	typedef struct packed {
		adbm_pkg::power_t left;
		adbm_pkg::power_t right;
		logic             bvalid;
		logic             bside;
		adbm_pkg::brake_t bamount;
	} mix_result_t;

	mix_result_t      mix_result_q[$];
	adbm_pkg::brake_t max_braking;

	function automatic mix_result_t mix_cmd(input adbm_pkg::cmd_t fwd_bits,
			input adbm_pkg::cmd_t trn_bits, input adbm_pkg::brake_t brk_max);
		int fwd;
		int trn;
		int abs_trn;
		int left;
		int right;
		int scaled;
		int amount;
		logic inboard_right;
		mix_result_t res;
		fwd = int'($signed(fwd_bits));
		trn = int'($signed(trn_bits));
		res = '0;
		if (fwd == 0) begin
			left = -trn;
			right = trn;
		end else begin
			abs_trn = (trn < 0) ? -trn : trn;
			left = fwd - trn;
			right = fwd + trn;
			inboard_right = (trn >= 0) ? (fwd < 0) : (fwd > 0);
			if (abs_trn < TurnDeadband) begin
				scaled = (fwd * (TurnDeadband - abs_trn)) / TurnDeadband;
				if (inboard_right)
					right = scaled;
				else
					left = scaled;
			end else begin
				amount = ((abs_trn - TurnDeadband) * (int'(brk_max) + 1))
					/ (FullScaleCounts - TurnDeadband);
				// A turn of -128 would overshoot the top level by one.
				if (amount > int'(brk_max))
					amount = int'(brk_max);
				if (inboard_right)
					right = 0;
				else
					left = 0;
				res.bvalid = 1'b1;
				res.bside = inboard_right;
				res.bamount = amount[adbm_pkg::BrakeW-1:0];
			end
		end
		res.left = left[adbm_pkg::PowerW-1:0];
		res.right = right[adbm_pkg::PowerW-1:0];
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		mix_result_t want;
		mix_result_t got;
		if (!arst_n) begin
			mix_result_q.delete();
			max_braking <= 8'd8;
			pending_count <= 0;
			mismatch_count = 0;
		end else begin
			if (cfg_wr_en)
				max_braking <= cfg_wr_data;
			if (out_valid && out_ready) begin
				got = '{left_power, right_power, brake_valid, brake_side, brake_amount};
				if (mix_result_q.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= MaxReported)
						$display("%0t: result beat with no command pending", $realtime);
				end else begin
					want = mix_result_q.pop_front();
					if (got != want) begin
						mismatch_count++;
						if (mismatch_count <= MaxReported)
							$display({"%0t: mismatch left %0d/%0d right %0d/%0d valid %0d/%0d",
								" side %0d/%0d amount %0d/%0d (expected/actual)"},
								$realtime, $signed(want.left), $signed(got.left),
								$signed(want.right), $signed(got.right),
								want.bvalid, got.bvalid, want.bside, got.bside,
								want.bamount, got.bamount);
					end
				end
			end
			if (in_valid && in_ready)
				mix_result_q.push_back(mix_cmd(forward_cmd, turn_cmd, max_braking));
			pending_count <= mix_result_q.size();
		end
	end

endmodule

// File: bench/tb_arcade_drive_brake_mixer.sv
// Top of the arcade drive brake mixer testbench: clock, reset, command and
// configuration stimulus, receiver stalls and the verdict.
// Depends on adbm_pkg, the block and adbm_mix_checker.
`timescale 1ns / 1ps

module tb_arcade_drive_brake_mixer;

	localparam int TurnDeadband    = 50;
	localparam int NumPhases       = 6;
	localparam int CmdsPerPhase    = 300;

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_ready;
	adbm_pkg::cmd_t   forward_cmd;
	adbm_pkg::cmd_t   turn_cmd;
	logic             cfg_wr_en;
	adbm_pkg::brake_t cfg_wr_data;
	logic             out_valid;
	logic             out_ready;
	adbm_pkg::power_t left_power;
	adbm_pkg::power_t right_power;
	logic             brake_valid;
	logic             brake_side;
	adbm_pkg::brake_t brake_amount;
	int               mismatch_count;
	int               pending_count;
	int               idle_pct;
	int               stall_pct;

	arcade_drive_brake_mixer #(
		.TURN_DEADBAND(TurnDeadband)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.forward_cmd(forward_cmd),
		.turn_cmd(turn_cmd),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.left_power(left_power),
		.right_power(right_power),
		.brake_valid(brake_valid),
		.brake_side(brake_side),
		.brake_amount(brake_amount)
	);

	adbm_mix_checker #(
		.TurnDeadband(TurnDeadband)
	) i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.forward_cmd(forward_cmd),
		.turn_cmd(turn_cmd),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.left_power(left_power),
		.right_power(right_power),
		.brake_valid(brake_valid),
		.brake_side(brake_side),
		.brake_amount(brake_amount),
		.mismatch_count(mismatch_count),
		.pending_count(pending_count)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("FAIL arcade_drive_brake_mixer");
		$finish;
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	task automatic send_cmd(input int fwd, input int trn);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			forward_cmd <= adbm_pkg::cmd_t'($urandom);
			turn_cmd <= adbm_pkg::cmd_t'($urandom);
			@(posedge clk);
		end
		in_valid <= 1'b1;
		forward_cmd <= fwd[7:0];
		turn_cmd <= trn[7:0];
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_max_braking(input adbm_pkg::brake_t level);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= level;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	function automatic int pick_cmd();
		case ($urandom_range(9))
			0: return 0;
			1: begin
				case ($urandom_range(4))
					0: return 127;
					1: return -128;
					2: return -127;
					3: return 1;
					default: return -1;
				endcase
			end
			2: return ($urandom_range(1) ? 1 : -1) * (TurnDeadband - 2 + $urandom_range(4));
			default: return int'($signed(8'($urandom)));
		endcase
	endfunction

	initial begin
		arst_n = 1'b0;
		in_valid <= 1'b0;
		forward_cmd <= '0;
		turn_cmd <= '0;
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= '0;
		idle_pct = 0;
		stall_pct = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed commands run at the reset brake level.
		send_cmd(0, 0);
		send_cmd(0, 127);
		send_cmd(0, -128);
		send_cmd(0, -127);
		send_cmd(127, 0);
		send_cmd(-128, 0);
		send_cmd(127, 127);
		send_cmd(127, -128);
		send_cmd(-128, -128);
		send_cmd(-128, 127);
		send_cmd(1, 49);
		send_cmd(1, 50);
		send_cmd(-1, -49);
		send_cmd(-1, -50);
		send_cmd(50, 49);
		send_cmd(100, -49);
		send_cmd(-100, 25);
		send_cmd(127, 51);
		send_cmd(-127, -127);
		send_cmd(5, -50);
		send_cmd(-5, 50);
		send_cmd(127, -1);
		send_cmd(-1, 1);
		send_cmd(-127, 127);
		wait_drained();

		for (int phase = 0; phase < NumPhases; phase++) begin
			case (phase)
				0: write_max_braking(8'd255);
				1: write_max_braking(8'd0);
				2: write_max_braking(8'd1);
				3: write_max_braking(8'd255);
				default: write_max_braking(adbm_pkg::brake_t'($urandom_range(255)));
			endcase
			case (phase % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 60; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 60; end
				default: begin idle_pct = 31; stall_pct = 31; end
			endcase
			for (int n = 0; n < CmdsPerPhase; n++)
				send_cmd(pick_cmd(), pick_cmd());
			wait_drained();
			idle_pct = 0;
			stall_pct = 0;
		end

		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && pending_count == 0)
			$display("PASS arcade_drive_brake_mixer");
		else
			$display("FAIL arcade_drive_brake_mixer");
		$finish;
	end

endmodule
